// File: hdl/dmq_pkg.sv
`timescale 1ns / 1ps

package dmq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [COUNT_W:0]   sum_t;

  // Lines of room a non-reply head entry needs
  localparam int NONREPLY_LINES = 2;

  // Request codes
  localparam logic [2:0] REQ_PUSH         = 3'd0;
  localparam logic [2:0] REQ_POP          = 3'd1;
  localparam logic [2:0] REQ_DROP_LATE    = 3'd2;
  localparam logic [2:0] REQ_DROP_SESSION = 3'd3;
  localparam logic [2:0] REQ_HAS_KIND     = 3'd4;
  localparam logic [2:0] REQ_FRONT_READY  = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LATE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_KIND = 2'd2;

  localparam logic [15:0] LATE_LIMIT_RST = 16'd2000;
  localparam logic [12:0] LINE_BYTES_RST = 13'd256;
  localparam logic [3:0]  REPLY_KIND_RST = 4'd0;

  typedef struct packed {
    logic [15:0] late_limit_ms;
    logic [12:0] line_bytes;
    logic [3:0]  reply_kind;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         item_kind;
    logic [7:0]         entry_arg;
    logic               session_mark;
    logic [31:0]        now_ms;
    logic signed [15:0] room_bytes;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       kind_found;
    logic       front_ready;
    logic [3:0] dropped_count;
    logic [3:0] entry_count;
    logic [3:0] head_kind;
    logic [7:0] head_arg;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  arg;
    logic        mark;
    logic [31:0] at;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Slot of the entry off places behind base, wrapping at the queue depth
  function automatic ptr_t ring_pos(ptr_t base, count_t off);
    sum_t sum;
    sum = sum_t'(base) + sum_t'(off);
    if (sum >= sum_t'(QUEUE_DEPTH)) sum = sum - sum_t'(QUEUE_DEPTH);
    return ptr_t'(sum);
  endfunction

endpackage

// File: hdl/dmq_ram.sv
`timescale 1ns / 1ps

module dmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/dmq_engine.sv
`timescale 1ns / 1ps

module dmq_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dmq_pkg::req_t req,
  input  dmq_pkg::cfg_t cfg,
  input  logic          take,
  output logic          busy,
  output logic          done,
  output dmq_pkg::rsp_t rsp
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_APPEND  = 3'd3;
  localparam logic [2:0] ST_HEAD_RD = 3'd4;
  localparam logic [2:0] ST_FINISH  = 3'd5;

  logic [2:0]      state, state_next;
  dmq_pkg::req_t   req_r;
  dmq_pkg::ptr_t   head, head_next;
  dmq_pkg::count_t fill, fill_next;
  dmq_pkg::count_t ri, ri_next;
  dmq_pkg::count_t ci, ci_next;
  logic            dv, dv_next;
  dmq_pkg::count_t kcnt, kcnt_next;
  dmq_pkg::count_t dropped, dropped_next;
  logic            accepted, accepted_next;
  logic            found, found_next;

  logic                          rd_en, wr_en;
  dmq_pkg::ptr_t                 rd_addr, wr_addr;
  dmq_pkg::entry_t               wr_data;
  logic [dmq_pkg::ENTRY_W-1:0]   rd_data;
  dmq_pkg::entry_t               ent;

  logic [31:0] age;
  logic        keep_head;
  logic        hit;
  logic [15:0] need;
  logic        ready;

  dmq_ram #(
    .WIDTH(dmq_pkg::ENTRY_W),
    .DEPTH(dmq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign ent = dmq_pkg::entry_t'(rd_data);

  // stop test for drop late: reply entry or not yet late
  assign age       = req_r.now_ms - ent.at;
  assign keep_head = (ent.kind == cfg.reply_kind) || (age <= 32'(cfg.late_limit_ms));

  always_comb begin
    hit = 1'b0;
    if (dv) begin
      case (req_r.req_type) inside
        dmq_pkg::REQ_PUSH, dmq_pkg::REQ_HAS_KIND: hit = (ent.kind == req_r.item_kind);
        dmq_pkg::REQ_DROP_LATE:                    hit = keep_head;
        default:                                   hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    fill_next     = fill;
    ri_next       = ri;
    ci_next       = ci;
    dv_next       = 1'b0;
    kcnt_next     = kcnt;
    dropped_next  = dropped;
    accepted_next = accepted;
    found_next    = found;
    rd_en         = 1'b0;
    rd_addr       = head;
    wr_en         = 1'b0;
    wr_addr       = head;
    wr_data       = ent;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next    = ST_EXEC;
          accepted_next = 1'b0;
          found_next    = 1'b0;
          dropped_next  = '0;
        end
      end

      ST_EXEC: begin
        ri_next   = '0;
        kcnt_next = '0;
        case (req_r.req_type) inside
          dmq_pkg::REQ_PUSH: begin
            state_next = (req_r.item_kind == cfg.reply_kind) ? ST_APPEND : ST_SCAN;
          end
          dmq_pkg::REQ_POP: begin
            if (fill != '0) begin
              head_next = dmq_pkg::ring_pos(head, dmq_pkg::count_t'(1));
              fill_next = fill - dmq_pkg::count_t'(1);
            end
            state_next = ST_HEAD_RD;
          end
          dmq_pkg::REQ_DROP_LATE, dmq_pkg::REQ_DROP_SESSION, dmq_pkg::REQ_HAS_KIND: begin
            state_next = ST_SCAN;
          end
          default: begin
            state_next = ST_HEAD_RD;
          end
        endcase
      end

      ST_SCAN: begin
        // compact kept entries behind the head; reads run ahead of writes
        if (dv && (req_r.req_type == dmq_pkg::REQ_DROP_SESSION)) begin
          if (ent.mark) begin
            dropped_next = dropped + dmq_pkg::count_t'(1);
          end else begin
            wr_en     = 1'b1;
            wr_addr   = dmq_pkg::ring_pos(head, kcnt);
            wr_data   = ent;
            kcnt_next = kcnt + dmq_pkg::count_t'(1);
          end
        end

        if (hit) begin
          state_next = ST_HEAD_RD;
          case (req_r.req_type)
            dmq_pkg::REQ_PUSH: begin
              accepted_next = 1'b1;
              if (!req_r.session_mark) begin
                wr_en   = 1'b1;
                wr_addr = dmq_pkg::ring_pos(head, ci);
                wr_data = '{kind: ent.kind, arg: ent.arg, mark: 1'b0, at: req_r.now_ms};
              end
            end
            dmq_pkg::REQ_HAS_KIND: begin
              found_next = 1'b1;
            end
            dmq_pkg::REQ_DROP_LATE: begin
              head_next    = dmq_pkg::ring_pos(head, ci);
              fill_next    = fill - ci;
              dropped_next = ci;
            end
            default: begin
            end
          endcase
        end else if (ri < fill) begin
          rd_en   = 1'b1;
          rd_addr = dmq_pkg::ring_pos(head, ri);
          ci_next = ri;
          ri_next = ri + dmq_pkg::count_t'(1);
          dv_next = 1'b1;
        end else if (!dv) begin
          // scan ran past the last entry
          state_next = ST_HEAD_RD;
          case (req_r.req_type)
            dmq_pkg::REQ_PUSH: begin
              state_next = ST_APPEND;
            end
            dmq_pkg::REQ_DROP_LATE: begin
              head_next    = dmq_pkg::ring_pos(head, fill);
              fill_next    = '0;
              dropped_next = fill;
            end
            dmq_pkg::REQ_DROP_SESSION: begin
              fill_next = kcnt;
            end
            default: begin
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (fill < dmq_pkg::count_t'(dmq_pkg::QUEUE_DEPTH)) begin
          wr_en         = 1'b1;
          wr_addr       = dmq_pkg::ring_pos(head, fill);
          wr_data       = '{kind: req_r.item_kind, arg: req_r.entry_arg,
                            mark: req_r.session_mark, at: req_r.now_ms};
          fill_next     = fill + dmq_pkg::count_t'(1);
          accepted_next = 1'b1;
        end
        state_next = ST_HEAD_RD;
      end

      ST_HEAD_RD: begin
        rd_en      = 1'b1;
        rd_addr    = head;
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      fill  <= '0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      dv    <= dv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= req;
    end
    ri       <= ri_next;
    ci       <= ci_next;
    kcnt     <= kcnt_next;
    dropped  <= dropped_next;
    accepted <= accepted_next;
    found    <= found_next;
  end

  // head entry read back in the last step feeds the front-ready check
  assign need  = (ent.kind == cfg.reply_kind) ? 16'(cfg.line_bytes)
                 : 16'(cfg.line_bytes) * 16'(dmq_pkg::NONREPLY_LINES);
  assign ready = (req_r.req_type == dmq_pkg::REQ_FRONT_READY) && (fill != '0)
                 && !req_r.room_bytes[15] && ($unsigned(req_r.room_bytes) >= need);

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_FINISH);

  assign rsp.accepted      = accepted;
  assign rsp.kind_found    = found;
  assign rsp.front_ready   = ready;
  assign rsp.dropped_count = 4'(dropped);
  assign rsp.entry_count   = 4'(fill);
  assign rsp.head_kind     = (fill != '0) ? ent.kind : 4'd0;
  assign rsp.head_arg      = (fill != '0) ? ent.arg : 8'd0;

endmodule

// File: hdl/dedup_message_queue.sv
`timescale 1ns / 1ps
// Deduplicating queue of pending output messages, held in an 8-entry RAM ring.
// Request channel: req_valid / req_stall / req_data. One request is taken at a
// time; req_stall stays high from the edge after acceptance until the result
// has moved into the response register.
// Response channel: rsp_valid / rsp_stall / rsp_data, one response per request,
// in request order, from a register that holds while rsp_stall is high. A new
// request is accepted while an earlier response still waits there.
// Pop, front ready and unknown codes go straight to the head read; a reply push
// appends first. Scanning requests (non-reply push, has kind, drop late, drop
// session) read entries from the head until the scan stops on an entry or runs
// through all queued entries. A push that finds no match appends after its scan.
// The scan is bound by the single read port of the entry RAM, one entry a cycle.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per cycle
// (0 late limit, 1 line bytes, 2 reply kind); write only while idle.
// Reset (rst, synchronous) empties the queue and loads the register defaults;
// the entry RAM is not cleared, since data read from it is used only for queued entries.
// If the receiver stalls, the response holds and one finished result can
// queue behind it inside the engine before req_stall backs up to the sender.

module dedup_message_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  dmq_pkg::req_t                   req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output dmq_pkg::rsp_t                   rsp_data,
  input  logic                            cfg_wr_en,
  input  logic [dmq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dmq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dmq_pkg::cfg_t cfg;
  dmq_pkg::rsp_t eng_rsp;
  logic          busy;
  logic          done;
  logic          start;
  logic          load;

  // Configuration registers; writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.late_limit_ms <= dmq_pkg::LATE_LIMIT_RST;
      cfg.line_bytes    <= dmq_pkg::LINE_BYTES_RST;
      cfg.reply_kind    <= dmq_pkg::REPLY_KIND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dmq_pkg::CFG_LATE_LIMIT: cfg.late_limit_ms <= cfg_data;
        dmq_pkg::CFG_LINE_BYTES: cfg.line_bytes    <= cfg_data[12:0];
        dmq_pkg::CFG_REPLY_KIND: cfg.reply_kind    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Take a request only when the engine is free
  assign req_stall = busy;
  assign start     = req_valid && !busy;

  dmq_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req_data),
    .cfg  (cfg),
    .take (load),
    .busy (busy),
    .done (done),
    .rsp  (eng_rsp)
  );

  // Response register: load when empty or being drained this cycle
  assign load = done && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= eng_rsp;
    end
  end

endmodule
